### hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL modules.
// Expects clk_i and rst_ni in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge out of reset
`define PFE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition must never be seen at a clock edge out of reset
`define PFE_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

### hw/rtl/pfe_pkg.sv
// Package for the Playfair fixed-square encoder: types, constants, square functions.
// No dependencies; used by every module of the block.
package pfe_pkg;

  localparam int unsigned IdxW    = 5;
  localparam int unsigned LetterW = 7;
  localparam int unsigned ByteW   = 8;

  typedef logic [IdxW-1:0]    sq_idx_t;
  typedef logic [2:0]         sq_pos_t;
  typedef logic [LetterW-1:0] letter_t;

  typedef struct packed {
    sq_idx_t first;
    sq_idx_t second;
    logic    run_last;
    logic    msg_last;
  } pair_cmd_t;

  typedef struct packed {
    letter_t c0;
    letter_t c1;
  } cipher_pair_t;

  localparam logic [ByteW-1:0] CharLowA   = 8'd97;
  localparam logic [ByteW-1:0] CharLowZ   = 8'd122;
  localparam logic [ByteW-1:0] CaseOffset = 8'd32;
  localparam logic [ByteW-1:0] CharA      = 8'd65;
  localparam logic [ByteW-1:0] CharB      = 8'd66;
  localparam logic [ByteW-1:0] CharI      = 8'd73;
  localparam logic [ByteW-1:0] CharJ      = 8'd74;
  localparam logic [ByteW-1:0] CharZ      = 8'd90;

  localparam sq_idx_t PadIdx    = 5'd22;
  localparam sq_idx_t FirstAfterJ = 5'd9;
  localparam sq_pos_t SideLast  = 3'd4;
  localparam sq_idx_t Side      = 5'd5;
  localparam letter_t AsciiLow  = 7'd65;
  localparam letter_t AsciiHigh = 7'd66;
  localparam letter_t AsciiJ    = 7'd74;
  localparam letter_t AsciiZ    = 7'd90;

  function automatic sq_pos_t row_of(sq_idx_t idx);
    sq_pos_t r;
    if (idx >= 5'd20)      r = 3'd4;
    else if (idx >= 5'd15) r = 3'd3;
    else if (idx >= 5'd10) r = 3'd2;
    else if (idx >= 5'd5)  r = 3'd1;
    else                   r = 3'd0;
    return r;
  endfunction

  function automatic sq_pos_t col_of(sq_idx_t idx);
    sq_idx_t base;
    base = 5'(row_of(idx)) * Side;
    return 3'(idx - base);
  endfunction

  function automatic sq_pos_t inc5(sq_pos_t p);
    return (p == SideLast) ? 3'd0 : p + 3'd1;
  endfunction

  function automatic letter_t cell_ascii(sq_pos_t r, sq_pos_t c);
    sq_idx_t idx;
    idx = 5'(r) * Side + 5'(c);
    return (idx < FirstAfterJ) ? (7'(idx) + AsciiLow) : (7'(idx) + AsciiHigh);
  endfunction

  function automatic cipher_pair_t encrypt(sq_idx_t a, sq_idx_t b);
    sq_pos_t      r1, c1, r2, c2;
    cipher_pair_t res;
    r1 = row_of(a);
    c1 = col_of(a);
    r2 = row_of(b);
    c2 = col_of(b);
    if (r1 == r2) begin
      res.c0 = cell_ascii(r1, inc5(c1));
      res.c1 = cell_ascii(r2, inc5(c2));
    end else if (c1 == c2) begin
      res.c0 = cell_ascii(inc5(r1), c1);
      res.c1 = cell_ascii(inc5(r2), c2);
    end else begin
      res.c0 = cell_ascii(r1, c2);
      res.c1 = cell_ascii(r2, c1);
    end
    return res;
  endfunction

endpackage

### hw/rtl/pfe_front.sv
// Front end: folds and classifies plaintext bytes, forms digraph commands.
// Depends on pfe_pkg and assert_macros.svh; feeds pfe_queue.
`include "assert_macros.svh"

module pfe_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_valid_i,
  input  logic [7:0]        s_byte_i,
  input  logic              s_end_i,
  output logic              s_ready_o,
  output logic              q_push_o,
  output pfe_pkg::pair_cmd_t q_cmd_o,
  input  logic              q_full_i
);

  logic               pend_valid_q, pend_valid_d;
  pfe_pkg::pair_cmd_t pend_cmd_q, pend_cmd_d;
  pfe_pkg::sq_idx_t   held_letter_q, held_letter_d;
  logic               held_valid_q, held_valid_d;

  logic               accept;
  logic               is_lower, is_letter, same;
  logic [7:0]         ch, chj;
  pfe_pkg::sq_idx_t   idx, held_mid;
  logic               held_valid_mid;
  logic               pair_a_vld, pair_e_vld;
  pfe_pkg::pair_cmd_t pair_a, pair_e, first_cmd;

  assign s_ready_o = !pend_valid_q && !q_full_i;
  assign accept    = s_valid_i && s_ready_o;

  always_comb begin
    is_lower  = (s_byte_i >= pfe_pkg::CharLowA) && (s_byte_i <= pfe_pkg::CharLowZ);
    ch        = is_lower ? (s_byte_i - pfe_pkg::CaseOffset) : s_byte_i;
    is_letter = (ch >= pfe_pkg::CharA) && (ch <= pfe_pkg::CharZ);
    chj       = (ch == pfe_pkg::CharJ) ? pfe_pkg::CharI : ch;
    idx       = (chj < pfe_pkg::CharJ) ? 5'(chj - pfe_pkg::CharA) : 5'(chj - pfe_pkg::CharB);
    same      = (held_letter_q == idx);

    pair_a_vld      = is_letter && held_valid_q;
    pair_a.first    = held_letter_q;
    pair_a.second   = same ? pfe_pkg::PadIdx : idx;
    held_valid_mid  = is_letter ? (held_valid_q ? same : 1'b1) : held_valid_q;
    held_mid        = (is_letter && !held_valid_q) ? idx : held_letter_q;

    pair_e_vld      = s_end_i && held_valid_mid;
    pair_e.first    = held_mid;
    pair_e.second   = pfe_pkg::PadIdx;
    pair_e.run_last = 1'b1;
    pair_e.msg_last = s_end_i;

    pair_a.run_last = !pair_e_vld;
    pair_a.msg_last = !pair_e_vld && s_end_i;

    first_cmd       = pair_a_vld ? pair_a : pair_e;
  end

  always_comb begin
    held_letter_d = held_letter_q;
    held_valid_d  = held_valid_q;
    pend_valid_d  = pend_valid_q;
    pend_cmd_d    = pend_cmd_q;
    q_push_o      = 1'b0;
    q_cmd_o       = first_cmd;
    if (pend_valid_q) begin
      q_cmd_o = pend_cmd_q;
      if (!q_full_i) begin
        q_push_o     = 1'b1;
        pend_valid_d = 1'b0;
      end
    end else if (accept) begin
      q_push_o      = pair_a_vld || pair_e_vld;
      pend_valid_d  = pair_a_vld && pair_e_vld;
      pend_cmd_d    = pair_e;
      held_valid_d  = s_end_i ? 1'b0 : held_valid_mid;
      held_letter_d = s_end_i ? '0 : held_mid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_valid_q  <= 1'b0;
      held_valid_q  <= 1'b0;
      held_letter_q <= '0;
    end else begin
      pend_valid_q  <= pend_valid_d;
      held_valid_q  <= held_valid_d;
      held_letter_q <= held_letter_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_cmd_q <= pend_cmd_d;
  end

  `PFE_ASSERT(a_split_pending, accept && pair_a_vld && pair_e_vld |=> pend_valid_q,
              "double digraph not held for second push")

endmodule

### hw/rtl/pfe_queue.sv
// Short command queue between front end and cipher back end.
// Depends on pfe_pkg and assert_macros.svh.
`include "assert_macros.svh"

module pfe_queue #(
  parameter int unsigned Depth = 4
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  pfe_pkg::pair_cmd_t cmd_i,
  output logic               full_o,
  input  logic               pop_i,
  output pfe_pkg::pair_cmd_t cmd_o,
  output logic               empty_o
);

  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW  = $clog2(Depth + 1);

  pfe_pkg::pair_cmd_t    mem_q [Depth];
  logic [AddrW-1:0]      wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]       count_q, count_d;

  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);
  assign cmd_o   = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == AddrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == AddrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

  `PFE_ASSERT_NEVER(a_no_overflow, push_i && full_o, "push into full queue")
  `PFE_ASSERT_NEVER(a_no_underflow, pop_i && empty_o, "pop from empty queue")
  `PFE_ASSERT(a_count_bound, count_q <= CntW'(Depth), "queue count beyond depth")

endmodule

### hw/rtl/pfe_back.sv
// Back end: encrypts one digraph from the queue and sends its two letters.
// Depends on pfe_pkg and assert_macros.svh.
`include "assert_macros.svh"

module pfe_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               q_empty_i,
  input  pfe_pkg::pair_cmd_t q_cmd_i,
  output logic               q_pop_o,
  output logic               m_tvalid_o,
  input  logic               m_tready_i,
  output logic [7:0]         m_tdata_o,
  output logic               m_tlast_o,
  output logic               m_tuser_o
);

  logic                  buf_valid_q, buf_valid_d;
  logic                  phase_q, phase_d;
  pfe_pkg::cipher_pair_t letters_q, letters_d;
  logic                  run_last_q, run_last_d;
  logic                  msg_last_q, msg_last_d;
  logic                  take;
  pfe_pkg::letter_t      cur_letter;

  assign take    = !q_empty_i && (!buf_valid_q || (phase_q && m_tready_i));
  assign q_pop_o = take;

  always_comb begin
    buf_valid_d = buf_valid_q;
    phase_d     = phase_q;
    letters_d   = letters_q;
    run_last_d  = run_last_q;
    msg_last_d  = msg_last_q;
    if (take) begin
      buf_valid_d = 1'b1;
      phase_d     = 1'b0;
      letters_d   = pfe_pkg::encrypt(q_cmd_i.first, q_cmd_i.second);
      run_last_d  = q_cmd_i.run_last;
      msg_last_d  = q_cmd_i.msg_last;
    end else if (buf_valid_q && m_tready_i) begin
      if (phase_q) begin
        buf_valid_d = 1'b0;
      end else begin
        phase_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buf_valid_q <= 1'b0;
      phase_q     <= 1'b0;
    end else begin
      buf_valid_q <= buf_valid_d;
      phase_q     <= phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    letters_q  <= letters_d;
    run_last_q <= run_last_d;
    msg_last_q <= msg_last_d;
  end

  assign cur_letter = phase_q ? letters_q.c1 : letters_q.c0;
  assign m_tvalid_o = buf_valid_q;
  assign m_tdata_o  = {1'b0, cur_letter};
  assign m_tlast_o  = phase_q && run_last_q;
  assign m_tuser_o  = phase_q && msg_last_q;

  `PFE_ASSERT(a_letter_range,
              m_tvalid_o |-> (cur_letter >= pfe_pkg::AsciiLow) &&
                             (cur_letter <= pfe_pkg::AsciiZ) &&
                             (cur_letter != pfe_pkg::AsciiJ),
              "cipher letter outside A..Z or equal to J")

endmodule

### hw/rtl/playfair_fixed_square_encoder.sv
// Channel | dir | tdata (low bit up)          | tlast        | tuser
// s_axis  | in  | [7:0] plain_byte            | message_end  | -
// m_axis  | out | [6:0] cipher_letter, [7] 0  | run_last     | message_last
//
// Top level of the Playfair encoder over the fixed A..Z (no J) square.
// Depends on pfe_pkg, pfe_front, pfe_queue, pfe_back.
// A byte is taken every cycle while the queue has room; one giving two digraphs
// blocks input until its second digraph is pushed. The back end sends one letter a
// cycle while m_axis_tready is high and the queue is not empty, two per digraph.
// Asynchronous active-low reset empties held letter, queue and output buffer.
// Output stalls back up through the queue to s_axis_tready only when it fills.
module playfair_fixed_square_encoder #(
  parameter int unsigned QueueDepth = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] plain_byte
  input  logic       s_axis_tlast,   // message_end
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [6:0] cipher_letter, [7] zero
  output logic       m_axis_tlast,   // run_last
  output logic       m_axis_tuser    // [0] message_last
);

  logic               q_push, q_full, q_pop, q_empty;
  pfe_pkg::pair_cmd_t q_cmd_in, q_cmd_out;

  pfe_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_byte_i  (s_axis_tdata),
    .s_end_i   (s_axis_tlast),
    .s_ready_o (s_axis_tready),
    .q_push_o  (q_push),
    .q_cmd_o   (q_cmd_in),
    .q_full_i  (q_full)
  );

  pfe_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .cmd_i   (q_cmd_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .cmd_o   (q_cmd_out),
    .empty_o (q_empty)
  );

  pfe_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_empty_i  (q_empty),
    .q_cmd_i    (q_cmd_out),
    .q_pop_o    (q_pop),
    .m_tvalid_o (m_axis_tvalid),
    .m_tready_i (m_axis_tready),
    .m_tdata_o  (m_axis_tdata),
    .m_tlast_o  (m_axis_tlast),
    .m_tuser_o  (m_axis_tuser)
  );

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 100ps
// Testbench for playfair_fixed_square_encoder: directed table, then random plaintext.
// Depends on pfe_pkg and the encoder RTL. Checks each beat against typed rows or a model.
module testbench;

  localparam int unsigned RandomItems   = 405;
  localparam int unsigned TailCycles    = 16;
  localparam int unsigned MaxPrinted    = 40;
  localparam int unsigned SquareSide    = 5;
  localparam int unsigned PadCell       = 22;
  localparam int unsigned UpperA        = 8'h41;
  localparam int unsigned UpperI        = 8'h49;
  localparam int unsigned UpperJ        = 8'h4A;
  localparam int unsigned UpperZ        = 8'h5A;
  localparam int unsigned LowerA        = 8'h61;
  localparam int unsigned LowerZ        = 8'h7A;
  localparam logic [7:0]  CaseBit       = 8'h20;

  typedef enum int unsigned {RX_OPEN, RX_COIN, RX_SPARSE, RX_CHOKE} rx_mode_e;

  typedef struct packed {
    pfe_pkg::letter_t letter;
    logic             run_end;
    logic             msg_end;
  } cipher_beat_t;

  typedef struct packed {
    logic [7:0]  plain;
    logic        fin;
    logic        typed;
    logic [2:0]  n;
    logic [31:0] letters;
  } plain_row_t;

  localparam int unsigned NumRows = 25;
  localparam plain_row_t DirectedRows [NumRows] = '{
    '{"A",   1'b0, 1'b1, 3'd0, 32'd0},
    '{"B",   1'b0, 1'b1, 3'd2, "BC"},
    '{"a",   1'b0, 1'b1, 3'd0, 32'd0},
    '{"z",   1'b0, 1'b1, 3'd2, "EV"},
    '{" ",   1'b0, 1'b1, 3'd0, 32'd0},
    '{8'hFF, 1'b0, 1'b1, 3'd0, 32'd0},
    '{8'h80, 1'b0, 1'b1, 3'd0, 32'd0},
    '{8'h00, 1'b0, 1'b1, 3'd0, 32'd0},
    '{"L",   1'b0, 1'b1, 3'd0, 32'd0},
    '{"L",   1'b0, 1'b1, 3'd2, "NV"},
    '{"Q",   1'b1, 1'b1, 3'd2, "QV"},
    '{"X",   1'b0, 1'b1, 3'd0, 32'd0},
    '{"x",   1'b1, 1'b1, 3'd4, "YYYY"},
    '{"J",   1'b0, 1'b1, 3'd0, 32'd0},
    '{"i",   1'b0, 1'b1, 3'd2, "HY"},
    '{"K",   1'b1, 1'b1, 3'd2, "KF"},
    '{"E",   1'b0, 1'b1, 3'd0, 32'd0},
    '{"Z",   1'b0, 1'b1, 3'd2, "KE"},
    '{"V",   1'b1, 1'b1, 3'd2, "WY"},
    '{"j",   1'b1, 1'b1, 3'd2, "HY"},
    '{"@",   1'b0, 1'b1, 3'd0, 32'd0},
    '{"[",   1'b0, 1'b0, 3'd0, 32'd0},
    '{"m",   1'b0, 1'b0, 3'd0, 32'd0},
    '{"n",   1'b1, 1'b0, 3'd0, 32'd0},
    '{"{",   1'b1, 1'b1, 3'd0, 32'd0}
  };

  logic       clk_i;
  logic       rst_ni;
  logic       s_axis_tvalid;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata;   // [7:0] plain_byte
  logic       s_axis_tlast;   // message_end
  logic       m_axis_tvalid;
  logic       m_axis_tready;
  logic [7:0] m_axis_tdata;   // [6:0] cipher_letter, [7] zero
  logic       m_axis_tlast;   // run_last
  logic       m_axis_tuser;   // [0] message_last

  cipher_beat_t     cipher_q[$];
  pfe_pkg::letter_t step_letters[$];
  logic [4:0]       open_cell;
  logic             open_held;
  int unsigned      burst_left;
  int unsigned      mismatches;
  rx_mode_e         rx_mode;
  int unsigned      rx_left;

  playfair_fixed_square_encoder u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .m_axis_tuser (m_axis_tuser)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic pfe_pkg::letter_t square_letter(int unsigned r, int unsigned c);
    int unsigned n;
    n = (r % SquareSide) * SquareSide + (c % SquareSide);
    return (n < 9) ? pfe_pkg::letter_t'(UpperA + n) : pfe_pkg::letter_t'(UpperA + 1 + n);
  endfunction

  task automatic cipher_pair(input int unsigned a, input int unsigned b);
    int unsigned r1, c1, r2, c2;
    r1 = a / SquareSide;
    c1 = a % SquareSide;
    r2 = b / SquareSide;
    c2 = b % SquareSide;
    if (r1 == r2) begin
      step_letters = {step_letters, square_letter(r1, c1 + 1)};
      step_letters = {step_letters, square_letter(r2, c2 + 1)};
    end else if (c1 == c2) begin
      step_letters = {step_letters, square_letter(r1 + 1, c1)};
      step_letters = {step_letters, square_letter(r2 + 1, c2)};
    end else begin
      step_letters = {step_letters, square_letter(r1, c2)};
      step_letters = {step_letters, square_letter(r2, c1)};
    end
  endtask

  task automatic encode_byte(input logic [7:0] b, input logic fin);
    int unsigned ch;
    int unsigned cell_no;
    ch = 32'(b);
    step_letters.delete();
    if (ch >= LowerA && ch <= LowerZ) ch = ch - CaseBit;
    if (ch >= UpperA && ch <= UpperZ) begin
      if (ch == UpperJ) ch = UpperI;
      cell_no = (ch < UpperJ) ? ch - UpperA : ch - UpperA - 1;
      if (!open_held) begin
        open_cell = 5'(cell_no);
        open_held = 1'b1;
      end else if (open_cell == 5'(cell_no)) begin
        cipher_pair(32'(open_cell), PadCell);
      end else begin
        cipher_pair(32'(open_cell), cell_no);
        open_held = 1'b0;
      end
    end
    if (fin) begin
      if (open_held) begin
        cipher_pair(32'(open_cell), PadCell);
        open_held = 1'b0;
      end
      open_cell = '0;
    end
  endtask

  task automatic report_mismatch(input string what);
    if (mismatches < MaxPrinted) $display("mismatch at %0t: %s", $realtime, what);
    mismatches++;
  endtask

  // Enter and leave at a falling edge; hold the beat until the handshake.
  task automatic send_beat(input logic [7:0] b, input logic fin, input logic typed,
                           input logic [2:0] n, input logic [31:0] want);
    int unsigned gap;
    cipher_beat_t beat;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= fin;
    do @(posedge clk_i); while (!s_axis_tready);
    encode_byte(b, fin);
    if (typed) begin
      step_letters.delete();
      for (int k = 0; k < n; k++)
        step_letters = {step_letters, pfe_pkg::letter_t'(want[8*(n-1-k) +: 8])};
    end
    foreach (step_letters[k]) begin
      beat.letter  = step_letters[k];
      beat.run_end = (k == step_letters.size() - 1);
      beat.msg_end = beat.run_end && fin;
      cipher_q = {cipher_q, beat};
    end
    @(negedge clk_i);
  endtask

  always @(negedge clk_i) begin
    if (rx_left == 0) begin
      rx_left = $urandom_range(16, 80);
      rx_mode = rx_mode_e'($urandom_range(0, 3));
    end
    rx_left--;
    case (rx_mode)
      RX_OPEN:   m_axis_tready <= 1'b1;
      RX_COIN:   m_axis_tready <= $urandom_range(0, 1);
      RX_SPARSE: m_axis_tready <= ($urandom_range(0, 3) == 0);
      default:   m_axis_tready <= ((rx_left % 12) >= 9);
    endcase
  end

  always @(posedge clk_i) begin
    cipher_beat_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (cipher_q.size() == 0) begin
        report_mismatch($sformatf("unexpected beat tdata=%h", m_axis_tdata));
      end else begin
        want = cipher_q.pop_front();
        if (m_axis_tdata !== {1'b0, want.letter})
          report_mismatch($sformatf("letter %h, want %h", m_axis_tdata, want.letter));
        if (m_axis_tlast !== want.run_end)
          report_mismatch($sformatf("run_last %b, want %b", m_axis_tlast, want.run_end));
        if (m_axis_tuser !== want.msg_end)
          report_mismatch($sformatf("message_last %b, want %b", m_axis_tuser, want.msg_end));
      end
    end
  end

  initial begin
    #4_000_000;
    $display("FAIL");
    $finish;
  end

  initial begin
    int unsigned items_sent;
    int unsigned pick;
    logic [7:0]  b;
    logic [7:0]  folded;
    logic [7:0]  prev_letter;
    logic        fin;
    clk_i         = 1'b0;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    m_axis_tready = 1'b0;
    open_cell     = '0;
    open_held     = 1'b0;
    burst_left    = 0;
    mismatches    = 0;
    rx_left       = 0;
    rx_mode       = RX_OPEN;
    items_sent    = 0;
    prev_letter   = "J";
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (int i = 0; i < NumRows; i++)
      send_beat(DirectedRows[i].plain, DirectedRows[i].fin, DirectedRows[i].typed,
                DirectedRows[i].n, DirectedRows[i].letters);

    while (items_sent < RandomItems) begin
      pick = $urandom_range(0, 99);
      if (pick < 55)      b = 8'(UpperA + $urandom_range(0, 25));
      else if (pick < 70) b = 8'(LowerA + $urandom_range(0, 25));
      else if (pick < 82) b = prev_letter ^ ($urandom_range(0, 1) ? CaseBit : 8'h00);
      else                b = 8'($urandom_range(0, 255));
      fin = ($urandom_range(0, 9) == 0);
      send_beat(b, fin, 1'b0, 3'd0, 32'd0);
      items_sent++;
      folded = b | CaseBit;
      if (folded >= LowerA && folded <= LowerZ) begin
        prev_letter = b;
      end
    end
    s_axis_tvalid <= 1'b0;

    while (cipher_q.size() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
